// ===== sv/apr_pkg.sv =====
// Shared types, default sizes and the gamma threshold function for the pixel resolve block.
package apr_pkg;

	// Default sizes of the fixed-point data path
	localparam int unsigned APR_FRAC_BITS   = 16;
	localparam int unsigned APR_SUM_WIDTH   = 32;
	localparam int unsigned APR_COUNT_WIDTH = 16;

	// Color channels handled side by side
	localparam int unsigned NUM_CH = 3;
	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	// Display code width and the number of levels it spans
	localparam int unsigned DISP_W     = 8;
	localparam int unsigned NUM_LEVELS = 1 << DISP_W;

	// One accumulated pixel
	typedef struct packed {
		logic [31:0] red_sum;
		logic [31:0] green_sum;
		logic [31:0] blue_sum;
		logic [15:0] sample_count;
	} pixel_t;

	// One resolved pixel
	typedef struct packed {
		logic [31:0] red_linear;
		logic [31:0] green_linear;
		logic [31:0] blue_linear;
		logic [7:0]  red_display;
		logic [7:0]  green_display;
		logic [7:0]  blue_display;
		logic        zero_count_error;
	} result_t;

	// Control that travels beside the data from cell to cell
	typedef struct packed {
		logic valid;
		logic zero_count;
	} ctl_t;

	// Smallest linear value L (frac fraction bits) that reaches display level k:
	// the least L with L^5 * 255^11 >= k^11 * 2^(5*frac). Evaluated at elaboration.
	function automatic logic [31:0] gamma_threshold(input int unsigned k, input int unsigned frac);
		logic [255:0] lhs;
		logic [255:0] rhs;
		logic [255:0] scale;
		logic [31:0]  lo;
		logic [31:0]  hi;
		logic [31:0]  mid;
		lhs = 256'd1;
		for (int i = 0; i < 11; i++) begin
			lhs = lhs * 256'(k);
		end
		lhs = lhs << (5 * frac);
		scale = 256'd1;
		for (int i = 0; i < 11; i++) begin
			scale = scale * 256'd255;
		end
		lo = 32'd0;
		hi = 32'd1 << frac;
		for (int it = 0; it < 32; it++) begin
			if (lo < hi) begin
				mid = (lo + hi) >> 1;
				rhs = scale;
				for (int j = 0; j < 5; j++) begin
					rhs = rhs * 256'(mid);
				end
				if (rhs >= lhs) begin
					hi = mid;
				end else begin
					lo = mid + 32'd1;
				end
			end
		end
		return lo;
	endfunction

endpackage

// ===== sv/apr_div_cell.sv =====
// One restoring division cell: produces one quotient bit per channel and hands on the rest.
module apr_div_cell import apr_pkg::*; #(
	parameter int unsigned SUM_WIDTH   = APR_SUM_WIDTH,
	parameter int unsigned COUNT_WIDTH = APR_COUNT_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  ctl_t                                  ctl,
	input  logic [COUNT_WIDTH-1:0]                divisor,
	input  logic [NUM_CH-1:0][COUNT_WIDTH-1:0]    rem,
	input  logic [NUM_CH-1:0][SUM_WIDTH-1:0]      dq,
	output ctl_t                                  ctl_q,
	output logic [COUNT_WIDTH-1:0]                divisor_q,
	output logic [NUM_CH-1:0][COUNT_WIDTH-1:0]    rem_q,
	output logic [NUM_CH-1:0][SUM_WIDTH-1:0]      dq_q
);

	logic [NUM_CH-1:0][COUNT_WIDTH:0]   trial;
	logic [NUM_CH-1:0][COUNT_WIDTH:0]   diff;
	logic [NUM_CH-1:0]                  fits;
	logic [NUM_CH-1:0][COUNT_WIDTH-1:0] rem_nxt;
	logic [NUM_CH-1:0][SUM_WIDTH-1:0]   dq_nxt;

	// Shift in the next dividend bit, subtract the divisor when it fits
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			trial[c]   = {rem[c], dq[c][SUM_WIDTH-1]};
			diff[c]    = trial[c] - {1'b0, divisor};
			fits[c]    = trial[c] >= {1'b0, divisor};
			rem_nxt[c] = fits[c] ? diff[c][COUNT_WIDTH-1:0] : trial[c][COUNT_WIDTH-1:0];
			dq_nxt[c]  = {dq[c][SUM_WIDTH-2:0], fits[c]};
		end
	end

	// Advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl;
		end
	end

	// Advance data
	always_ff @(posedge clk) begin
		if (adv) begin
			divisor_q <= divisor;
			rem_q     <= rem_nxt;
			dq_q      <= dq_nxt;
		end
	end

endmodule

// ===== sv/apr_gamma_cell.sv =====
// One binary search cell of the gamma encoder: settles one bit of each display code.
module apr_gamma_cell import apr_pkg::*; #(
	parameter int unsigned FRAC_BITS = APR_FRAC_BITS,
	parameter int unsigned SUM_WIDTH = APR_SUM_WIDTH,
	parameter int unsigned BIT       = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  ctl_t                               ctl,
	input  logic [NUM_CH-1:0][SUM_WIDTH-1:0]   lin,
	input  logic [NUM_CH-1:0][DISP_W-1:0]      code,
	output ctl_t                               ctl_q,
	output logic [NUM_CH-1:0][SUM_WIDTH-1:0]   lin_q,
	output logic [NUM_CH-1:0][DISP_W-1:0]      code_q
);

	localparam logic [DISP_W-1:0] STEP = DISP_W'(1 << BIT);

	logic [FRAC_BITS:0]                thr [NUM_LEVELS];
	logic [NUM_CH-1:0][FRAC_BITS:0]    level;
	logic [NUM_CH-1:0][DISP_W-1:0]     cand;
	logic [NUM_CH-1:0][DISP_W-1:0]     code_nxt;

	// Build the threshold table at elaboration
	for (genvar k = 0; k < NUM_LEVELS; k++) begin : g_thr
		localparam logic [31:0] THR_W = gamma_threshold(k, FRAC_BITS);
		assign thr[k] = THR_W[FRAC_BITS:0];
	end

	// Clamp each linear value to one; the top level's threshold equals one
	for (genvar c = 0; c < NUM_CH; c++) begin : g_clamp
		if (SUM_WIDTH > FRAC_BITS) begin : g_wide
			assign level[c] = (|lin[c][SUM_WIDTH-1:FRAC_BITS]) ?
				{1'b1, {FRAC_BITS{1'b0}}} : {1'b0, lin[c][FRAC_BITS-1:0]};
		end else begin : g_narrow
			assign level[c] = (FRAC_BITS + 1)'(lin[c]);
		end
	end

	// Try setting this bit of the code; keep it when the level reaches the threshold
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			cand[c]     = code[c] | STEP;
			code_nxt[c] = (level[c] >= thr[cand[c]]) ? cand[c] : code[c];
		end
	end

	// Advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl;
		end
	end

	// Advance data
	always_ff @(posedge clk) begin
		if (adv) begin
			lin_q  <= lin;
			code_q <= code_nxt;
		end
	end

endmodule

// ===== sv/accumulated_pixel_resolve_gamma.sv =====
// Accumulated pixel resolve: divide the channel sums by the sample count and gamma encode them.
// One pixel is accepted per clock while pixel_stall is low and one result leaves per clock while
// result_stall is low. A pixel passes a row of SUM_WIDTH division cells, each settling one
// quotient bit of all three channels, then eight gamma cells, each settling one bit of the
// display codes by comparing against a threshold table, then the result register. A skid
// register behind the result register holds one item while result_stall is high;
// pixel_stall is raised only while that skid register is full, and the whole row of cells
// holds then. A zero sample count gives zero outputs and sets zero_count_error.
module accumulated_pixel_resolve_gamma import apr_pkg::*; #(
	parameter int unsigned FRAC_BITS   = APR_FRAC_BITS,
	parameter int unsigned SUM_WIDTH   = APR_SUM_WIDTH,
	parameter int unsigned COUNT_WIDTH = APR_COUNT_WIDTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pixel_valid,
	output logic    pixel_stall,
	input  pixel_t  pixel,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int unsigned NDIV = SUM_WIDTH;
	localparam int unsigned NGAM = DISP_W;

	logic adv;

	ctl_t                                div_ctl [NDIV+1];
	logic [COUNT_WIDTH-1:0]              div_den [NDIV+1];
	logic [NUM_CH-1:0][COUNT_WIDTH-1:0]  div_rem [NDIV+1];
	logic [NUM_CH-1:0][SUM_WIDTH-1:0]    div_dq  [NDIV+1];

	ctl_t                                gam_ctl  [NGAM+1];
	logic [NUM_CH-1:0][SUM_WIDTH-1:0]    gam_lin  [NGAM+1];
	logic [NUM_CH-1:0][DISP_W-1:0]       gam_code [NGAM+1];

	result_t pipe_res;
	logic    pipe_valid;
	logic    res_valid_q;
	result_t res_q;
	logic    skid_valid_q;
	result_t skid_q;

	// Hold the row while the skid register is occupied
	assign adv         = ~skid_valid_q;
	assign pixel_stall = skid_valid_q;

	// Feed the first division cell
	assign div_ctl[0].valid      = pixel_valid & ~pixel_stall;
	assign div_ctl[0].zero_count = (COUNT_WIDTH'(pixel.sample_count) == '0);
	assign div_den[0]            = COUNT_WIDTH'(pixel.sample_count);
	assign div_rem[0]            = '0;
	assign div_dq[0][CH_RED]     = SUM_WIDTH'(pixel.red_sum);
	assign div_dq[0][CH_GREEN]   = SUM_WIDTH'(pixel.green_sum);
	assign div_dq[0][CH_BLUE]    = SUM_WIDTH'(pixel.blue_sum);

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		apr_div_cell #(
			.SUM_WIDTH   (SUM_WIDTH),
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.ctl       (div_ctl[i]),
			.divisor   (div_den[i]),
			.rem       (div_rem[i]),
			.dq        (div_dq[i]),
			.ctl_q     (div_ctl[i+1]),
			.divisor_q (div_den[i+1]),
			.rem_q     (div_rem[i+1]),
			.dq_q      (div_dq[i+1])
		);
	end

	// Quotients enter the gamma search with an empty code
	assign gam_ctl[0]  = div_ctl[NDIV];
	assign gam_lin[0]  = div_dq[NDIV];
	assign gam_code[0] = '0;

	for (genvar g = 0; g < NGAM; g++) begin : g_gam
		apr_gamma_cell #(
			.FRAC_BITS (FRAC_BITS),
			.SUM_WIDTH (SUM_WIDTH),
			.BIT       (NGAM - 1 - g)
		) u_gam (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl    (gam_ctl[g]),
			.lin    (gam_lin[g]),
			.code   (gam_code[g]),
			.ctl_q  (gam_ctl[g+1]),
			.lin_q  (gam_lin[g+1]),
			.code_q (gam_code[g+1])
		);
	end

	// Form the result item; force zeros on a zero count
	always_comb begin
		pipe_valid = gam_ctl[NGAM].valid;
		if (gam_ctl[NGAM].zero_count) begin
			pipe_res                  = '0;
			pipe_res.zero_count_error = 1'b1;
		end else begin
			pipe_res.red_linear       = 32'(gam_lin[NGAM][CH_RED]);
			pipe_res.green_linear     = 32'(gam_lin[NGAM][CH_GREEN]);
			pipe_res.blue_linear      = 32'(gam_lin[NGAM][CH_BLUE]);
			pipe_res.red_display      = gam_code[NGAM][CH_RED];
			pipe_res.green_display    = gam_code[NGAM][CH_GREEN];
			pipe_res.blue_display     = gam_code[NGAM][CH_BLUE];
			pipe_res.zero_count_error = 1'b0;
		end
	end

	// Output and skid control: park the item in the skid register when the output is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!result_stall) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid_q && result_stall) begin
			skid_valid_q <= pipe_valid;
		end else begin
			res_valid_q <= pipe_valid;
		end
	end

	// Output and skid data
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!result_stall) begin
				res_q <= skid_q;
			end
		end else if (res_valid_q && result_stall) begin
			skid_q <= pipe_res;
		end else begin
			res_q <= pipe_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
